// ----- rtl/slpe_pkg.sv -----
// slpe_pkg: shared types and codes for the sorted list pool engine
// payload structs, command and status codes, sequencer states
// no dependencies
`default_nettype none

package slpe_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_MISS  = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] item;
    } slpe_in_t;

    typedef struct packed {
        logic       found;
        logic       pred_valid;
        logic [3:0] pred_index;
        logic [3:0] slot;
        logic [1:0] status;
        logic       is_empty;
        logic       is_full;
    } slpe_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_ACT,
        ST_LINK,
        ST_DONE
    } slpe_state_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_list_pool_engine_core.sv -----
// sorted_list_pool_engine_core: top level of the sorted list pool engine
// depends on slpe_pkg; holds the node value and node link memories
//
// Keeps an ascending linked list of signed 32-bit values in a pool of POOL_NODES
// nodes, with unused nodes on a free list. One command is worked at a time:
// after a command beat is taken, the list is walked from its head one node per
// cycle, each step being one read of the value and link memories, until the
// first node not smaller than the item or the end of the list. Then, for an
// insert or delete that goes ahead, the ACT and LINK states relink the list,
// and the DONE state loads the response register. The walk reads from 0 up to
// POOL_NODES nodes. A response beat still waiting on rsp_ready holds the next
// command in the DONE state until it is taken. No clearing pass is needed after
// reset: a fill count stands in for the initial free chain, so commands are
// taken at once.
`default_nettype none

module sorted_list_pool_engine_core #(
    parameter int POOL_NODES = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_ready,
    input  slpe_pkg::slpe_in_t  cmd_data,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output slpe_pkg::slpe_out_t rsp_data
);
    import slpe_pkg::*;

    localparam int IW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    logic signed [31:0] val_mem [POOL_NODES];
    logic [LW-1:0]      link_mem [POOL_NODES];

    slpe_state_t        state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic signed [31:0] item_reg, item_next;
    logic [LW-1:0]      cur_reg, cur_next;
    logic [LW-1:0]      pred_reg, pred_next;
    logic [LW-1:0]      steps_reg, steps_next;
    logic               found_reg, found_next;
    logic [LW-1:0]      link_cur_reg, link_cur_next;
    logic [LW-1:0]      slot_reg, slot_next;
    logic [1:0]         status_reg, status_next;
    logic [LW-1:0]      list_head_reg, list_head_next;
    logic [LW-1:0]      free_head_reg, free_head_next;
    logic [LW-1:0]      fill_reg, fill_next;
    slpe_out_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic signed [31:0] val_rdata_reg;
    logic [LW-1:0]      link_rdata_reg;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               val_we;
    logic [IW-1:0]      val_waddr;
    logic               link_we;
    logic [IW-1:0]      link_waddr;
    logic [LW-1:0]      link_wdata;

    logic               stop_hit;
    logic               walk_more;
    logic [LW-1:0]      steps_inc;
    logic               list_empty;
    logic               pool_full;
    logic               del_ok;

    assign steps_inc  = steps_reg + 1'b1;
    assign stop_hit   = item_reg <= val_rdata_reg;
    assign walk_more  = !stop_hit && (link_rdata_reg < NIL) && (steps_inc < NIL);
    assign list_empty = !(list_head_reg < NIL);
    assign pool_full  = !(free_head_reg < NIL);
    assign del_ok     = found_reg && (cur_reg < NIL);

    // memories
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= item_reg;
        end
        if (rd_en)
        begin
            val_rdata_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en)
        begin
            link_rdata_reg <= link_mem[rd_addr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = !list_empty ? ST_WALK : ST_ACT;
                end
            end
            ST_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                if ((cmd_reg == CMD_INSERT && !pool_full) ||
                    (cmd_reg == CMD_DELETE && !list_empty && del_ok))
                begin
                    state_next = ST_LINK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LINK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd_next       = cmd_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        pred_next      = pred_reg;
        steps_next     = steps_reg;
        found_next     = found_reg;
        link_cur_next  = link_cur_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = list_head_reg[IW-1:0];
        val_we         = 1'b0;
        val_waddr      = free_head_reg[IW-1:0];
        link_we        = 1'b0;
        link_waddr     = pred_reg[IW-1:0];
        link_wdata     = free_head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd_data.command;
                    item_next  = cmd_data.item;
                    cur_next   = list_head_reg;
                    pred_next  = NIL;
                    steps_next = '0;
                    found_next = 1'b0;
                    slot_next  = '0;
                    rd_en      = !list_empty;
                    rd_addr    = list_head_reg[IW-1:0];
                end
            end
            ST_WALK:
            begin
                if (stop_hit)
                begin
                    found_next    = item_reg == val_rdata_reg;
                    link_cur_next = link_rdata_reg;
                end
                else
                begin
                    pred_next  = cur_reg;
                    cur_next   = link_rdata_reg;
                    steps_next = steps_inc;
                    rd_en      = walk_more;
                    rd_addr    = link_rdata_reg[IW-1:0];
                end
            end
            ST_ACT:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (pool_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            status_next = STAT_OK;
                            slot_next   = free_head_reg;
                            rd_en       = 1'b1;
                            rd_addr     = free_head_reg[IW-1:0];
                            val_we      = 1'b1;
                            val_waddr   = free_head_reg[IW-1:0];
                            link_we     = pred_reg < NIL;
                            link_waddr  = pred_reg[IW-1:0];
                            link_wdata  = free_head_reg;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (list_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (!del_ok)
                        begin
                            status_next = STAT_MISS;
                        end
                        else
                        begin
                            status_next = STAT_OK;
                            slot_next   = cur_reg;
                            if (pred_reg < NIL)
                            begin
                                link_we    = 1'b1;
                                link_waddr = pred_reg[IW-1:0];
                                link_wdata = link_cur_reg;
                            end
                            else
                            begin
                                list_head_next = link_cur_reg;
                            end
                        end
                    end
                    default:
                    begin
                        if (list_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (!found_reg)
                        begin
                            status_next = STAT_MISS;
                        end
                        else
                        begin
                            status_next = STAT_OK;
                        end
                    end
                endcase
            end
            ST_LINK:
            begin
                link_we = 1'b1;
                if (cmd_reg == CMD_INSERT)
                begin
                    link_waddr = slot_reg[IW-1:0];
                    link_wdata = cur_reg;
                    if (!(pred_reg < NIL))
                    begin
                        list_head_next = slot_reg;
                    end
                    // untouched tail of the pool chains in index order
                    if (slot_reg >= fill_reg)
                    begin
                        free_head_next = slot_reg + 1'b1;
                        fill_next      = fill_reg + 1'b1;
                    end
                    else
                    begin
                        free_head_next = link_rdata_reg;
                    end
                end
                else
                begin
                    link_waddr     = cur_reg[IW-1:0];
                    link_wdata     = free_head_reg;
                    free_head_next = cur_reg;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.found      = found_reg;
                    rsp_next.pred_valid = pred_reg < NIL;
                    rsp_next.pred_index = (pred_reg < NIL) ? 4'(pred_reg) : 4'd0;
                    rsp_next.slot       = 4'(slot_reg);
                    rsp_next.status     = status_reg;
                    rsp_next.is_empty   = list_empty;
                    rsp_next.is_full    = pool_full;
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            list_head_reg <= NIL;
            free_head_reg <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        item_reg     <= item_next;
        cur_reg      <= cur_next;
        pred_reg     <= pred_next;
        steps_reg    <= steps_next;
        found_reg    <= found_next;
        link_cur_reg <= link_cur_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/slpe_checker.sv -----
// slpe_checker: port-level assertions for sorted_list_pool_engine_core
// depends on slpe_pkg; bound to the top level at the end of this file
`default_nettype none

module slpe_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 cmd_valid,
    input wire                 cmd_ready,
    input wire                 rsp_valid,
    input wire                 rsp_ready,
    input slpe_pkg::slpe_out_t rsp_data
);
    import slpe_pkg::*;

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response beat changed while stalled");

    // one command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is at work");

    // list and free list share the whole pool
    a_pool_split: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full))
        else $error("list empty and pool full at once");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == STAT_FULL |-> rsp_data.is_full)
        else $error("pool full status without full flag");

    a_empty_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == STAT_EMPTY
            |-> !rsp_data.found && !rsp_data.pred_valid && rsp_data.is_empty)
        else $error("empty list status with walk results");

endmodule

bind sorted_list_pool_engine_core slpe_checker u_slpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire
